@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the gyro bias tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ilgb_pkg.sv @@
// Types and constants shared by the gyro bias tracker modules.
`default_nettype none

package ilgb_pkg;

   localparam int NUM_AXES = 6;
   localparam int AXIS_AX  = 0;
   localparam int AXIS_AY  = 1;
   localparam int AXIS_AZ  = 2;
   localparam int AXIS_GX  = 3;
   localparam int AXIS_GY  = 4;
   localparam int AXIS_GZ  = 5;

   localparam int RAW_W  = 16;
   localparam int FILT_W = 24;
   localparam int DIFF_W = 25;
   localparam int SUM_W  = 32;
   localparam int RATE_W = 24;
   localparam int THR_W  = 11;
   localparam int WGT_W  = 9;

   // Configuration register indexes.
   localparam logic CSR_STILL_THRESHOLD = 1'b0;
   localparam logic CSR_FILTER_WEIGHT   = 1'b1;

   localparam logic [THR_W-1:0] THR_RESET = 11'd8;
   localparam logic [WGT_W-1:0] WGT_RESET = 9'd182;
   localparam logic [WGT_W-1:0] WGT_FULL  = 9'd256;

   // round(2^24 * 256 / (16.4 * 57.29578)): Q15.8 raw counts to Q.16 rad/s.
   localparam logic signed [23:0] RATE_GAIN = 24'sd4570812;

   typedef logic signed [FILT_W-1:0] filt_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [RATE_W-1:0] rate_type;

   // Which bias a mean computation belongs to.
   typedef logic [1:0] bias_sel_type;
   localparam bias_sel_type BIAS_X = 2'd0;
   localparam bias_sel_type BIAS_Y = 2'd1;
   localparam bias_sel_type BIAS_Z = 2'd2;

   typedef struct packed {
      logic         valid;
      bias_sel_type sel;
      sum_type      sum;
   } div_req_type;

   typedef struct packed {
      logic         valid;
      bias_sel_type sel;
      filt_type     mean;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ hdl/ilgb_filter_lane.sv @@
// One first-order low-pass filter lane for a single IMU axis.
`default_nettype none

module ilgb_filter_lane (
   input  wire                                 clock,
   input  wire                                 load,
   input  wire                                 seed,
   input  wire  [ilgb_pkg::WGT_W-1:0]          weight,
   input  wire  signed [ilgb_pkg::RAW_W-1:0]   raw,
   output ilgb_pkg::filt_type                  filt
);

   ilgb_pkg::filt_type  f_ff;
   ilgb_pkg::filt_type  f_in;
   ilgb_pkg::filt_type  raw_q8;
   ilgb_pkg::diff_type  delta;
   logic signed [34:0]  num;
   logic signed [34:0]  rnd;

   // (256 - w) * f + w * r equals 256 * f + w * (r - f), which needs one multiplier.
   always_comb begin
      raw_q8 = {raw, 8'b0};
      delta  = ilgb_pkg::diff_type'(raw_q8) - ilgb_pkg::diff_type'(f_ff);
      num    = 35'(delta) * 35'($signed({1'b0, weight}))
             + (35'(f_ff) <<< 8);
      // Round to nearest with ties away from zero before the shift.
      rnd    = num + (num[34] ? 35'sd127 : 35'sd128);
      f_in   = seed ? raw_q8 : rnd[31:8];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         f_ff <= f_in;
      end
   end

   assign filt = f_ff;

endmodule

`default_nettype wire

@@ hdl/ilgb_rate_lane.sv @@
// One rate conversion lane: Q15.8 bias-corrected count to Q.16 rad/s.
`default_nettype none

module ilgb_rate_lane (
   input  wire                 clock,
   input  ilgb_pkg::diff_type  diff,
   output ilgb_pkg::rate_type  rate
);

   logic signed [47:0] prod_ff;
   logic signed [47:0] prod_in;
   logic signed [47:0] rnd;

   assign prod_in = 48'(diff) * 48'(ilgb_pkg::RATE_GAIN);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Divide by 2^24, rounding to nearest with ties away from zero.
   always_comb begin
      rnd = prod_ff + (prod_ff[47] ? 48'sh7FFFFF : 48'sh800000);
   end

   assign rate = rnd[47:24];

endmodule

`default_nettype wire

@@ hdl/ilgb_mean_div.sv @@
// Pipelined rounded division of a signed sum by the window length.
`default_nettype none

module ilgb_mean_div #(
   parameter int WINDOW = 100
) (
   input  wire                    clock,
   input  wire                    reset,
   input  ilgb_pkg::div_req_type  req,
   output ilgb_pkg::div_rsp_type  rsp
);

   localparam logic [31:0] HALF  = 32'(WINDOW / 2);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / WINDOW);
   localparam logic [8:0]  WIN   = 9'(WINDOW);
   localparam int          QW    = 25;

   logic                   s0_v_ff, s1_v_ff, s2_v_ff;
   ilgb_pkg::bias_sel_type s0_sel_ff, s1_sel_ff, s2_sel_ff;
   logic                   s0_neg_ff, s1_neg_ff, s2_neg_ff;
   logic [31:0]            s0_mag_ff, s1_mag_ff;
   logic [QW-1:0]          s1_q_ff, s2_q_ff;

   logic [31:0]            abs_in;
   logic [31:0]            mag_in;
   logic [63:0]            prod;
   logic [31:0]            rem;
   logic [QW-1:0]          q_in;
   logic signed [QW-1:0]   mean_full;

   always_comb begin
      abs_in = req.sum[31] ? 32'(-req.sum) : 32'(req.sum);
      mag_in = abs_in + HALF;
      prod   = 64'(s0_mag_ff) * 64'(RECIP);
      // The reciprocal estimate is low by at most one; one compare fixes it.
      rem    = s1_mag_ff - 32'(34'(s1_q_ff) * 34'(WIN));
      q_in   = s1_q_ff + QW'(rem >= 32'(WIN));
      mean_full = s2_neg_ff ? -$signed(s2_q_ff) : $signed(s2_q_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= req.valid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_sel_ff <= req.sel;
      s0_neg_ff <= req.sum[31];
      s0_mag_ff <= mag_in;
      s1_sel_ff <= s0_sel_ff;
      s1_neg_ff <= s0_neg_ff;
      s1_mag_ff <= s0_mag_ff;
      s1_q_ff   <= prod[32 +: QW];
      s2_sel_ff <= s1_sel_ff;
      s2_neg_ff <= s1_neg_ff;
      s2_q_ff   <= q_in;
   end

   always_comb begin
      rsp.valid = s2_v_ff;
      rsp.sel   = s2_sel_ff;
      rsp.mean  = mean_full[ilgb_pkg::FILT_W-1:0];
   end

endmodule

`default_nettype wire

@@ hdl/imu_lowpass_gyro_bias_tracker.sv @@
// An accepted word waits in the filter state until taken, then passes r1, r2 and the
// output register. Throughput: calibration words 1 per cycle; a result word is taken
// only when r1 and r2 are empty. The word ending calibration holds the next word until
// three means leave the 3-stage reciprocal divider; a still z word, until its mean does.
// Reset is synchronous: it clears counters, sums, biases and handshake state and
// loads the register defaults; the z window memory is not cleared.
`default_nettype none
`include "assert_macros.svh"

module imu_lowpass_gyro_bias_tracker #(
   parameter int WINDOW = 100
) (
   input  wire          clock,
   input  wire          reset,
   // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
   input  wire  [95:0]  req_tdata,
   input  wire          req_tvalid,
   output logic         req_tready,
   // accel_x_filtered, accel_y_filtered, accel_z_filtered, rate_x, rate_y, rate_z
   output logic [143:0] rsp_tdata,
   // z_still
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   input  wire          csr_we,
   input  wire  [0:0]   csr_index,
   input  wire  [10:0]  csr_wdata
);

   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW = $clog2(WINDOW + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_ISSUE_X = 2'd1;
   localparam logic [1:0] ST_ISSUE_Y = 2'd2;
   localparam logic [1:0] ST_ISSUE_Z = 2'd3;

   // Configuration.
   logic [ilgb_pkg::THR_W-1:0] thr_ff;
   logic [ilgb_pkg::WGT_W-1:0] wgt_ff;
   logic [ilgb_pkg::WGT_W-1:0] wgt_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ilgb_pkg::THR_RESET;
         wgt_ff <= ilgb_pkg::WGT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ilgb_pkg::CSR_STILL_THRESHOLD: thr_ff <= csr_wdata;
            ilgb_pkg::CSR_FILTER_WEIGHT:   wgt_ff <= csr_wdata[ilgb_pkg::WGT_W-1:0];
            default: ;
         endcase
      end
   end

   assign wgt_eff = (wgt_ff > ilgb_pkg::WGT_FULL) ? ilgb_pkg::WGT_FULL : wgt_ff;

   // Control and merge state.
   logic                    seeded_ff, seeded_in;
   logic                    job_v_ff, job_v_in;
   logic [1:0]              state_ff, state_in;
   logic [1:0]              pend_ff, pend_in;
   logic [CW-1:0]           cal_cnt_ff, cal_cnt_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   ilgb_pkg::sum_type       x_sum_ff, x_sum_in;
   ilgb_pkg::sum_type       y_sum_ff, y_sum_in;
   ilgb_pkg::sum_type       z_sum_ff, z_sum_in;
   ilgb_pkg::filt_type      bias_x_ff, bias_x_in;
   ilgb_pkg::filt_type      bias_y_ff, bias_y_in;
   ilgb_pkg::filt_type      bias_z_ff, bias_z_in;

   // Result pipeline.
   logic                    r1_v_ff, r2_v_ff, out_v_ff;
   logic                    r1_v_in, out_v_in;
   ilgb_pkg::filt_type      a1_ff [3];
   ilgb_pkg::filt_type      a2_ff [3];
   ilgb_pkg::diff_type      d1_ff [3];
   logic                    still1_ff, still2_ff;
   logic [143:0]            out_data_ff;
   logic                    out_still_ff;

   // Window memory.
   ilgb_pkg::filt_type      win_mem [WINDOW];
   ilgb_pkg::filt_type      rd_ff;
   logic                    mem_we;
   logic [AW-1:0]           mem_addr;

   ilgb_pkg::filt_type      filt [ilgb_pkg::NUM_AXES];
   ilgb_pkg::rate_type      rate [3];
   ilgb_pkg::diff_type      dz;
   logic [ilgb_pkg::DIFF_W-1:0] dz_mag;
   logic                    still;
   logic                    cal_done;
   logic                    room;
   logic                    take;
   logic                    accept;
   ilgb_pkg::div_req_type   div_req;
   ilgb_pkg::div_rsp_type   div_rsp;

   assign accept = req_tvalid && req_tready;

   // Six filter lanes, one per axis; the filter state holds the word under work.
   for (genvar i = 0; i < ilgb_pkg::NUM_AXES; i++) begin : g_filt
      ilgb_filter_lane u_lane (
         .clock  (clock),
         .load   (accept),
         .seed   (!seeded_ff),
         .weight (wgt_eff),
         .raw    (req_tdata[ilgb_pkg::RAW_W*i +: ilgb_pkg::RAW_W]),
         .filt   (filt[i])
      );
   end

   for (genvar i = 0; i < 3; i++) begin : g_rate
      ilgb_rate_lane u_rate (
         .clock (clock),
         .diff  (d1_ff[i]),
         .rate  (rate[i])
      );
   end

   ilgb_mean_div #(
      .WINDOW (WINDOW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      cal_done = (cal_cnt_ff == CW'(WINDOW));
      room     = !r1_v_ff && !r2_v_ff && (!out_v_ff || rsp_tready);
      take     = job_v_ff && (state_ff == ST_IDLE) && (pend_ff == 2'd0)
                 && (!cal_done || room);
      req_tready = !job_v_ff || take;

      dz     = ilgb_pkg::diff_type'(filt[ilgb_pkg::AXIS_GZ])
             - ilgb_pkg::diff_type'(bias_z_ff);
      dz_mag = dz[ilgb_pkg::DIFF_W-1] ? ilgb_pkg::DIFF_W'(-dz) : ilgb_pkg::DIFF_W'(dz);
      still  = dz_mag < ilgb_pkg::DIFF_W'({thr_ff, 8'b0});
   end

   // Merge stage: calibration sums, window update and bias tracking.
   always_comb begin
      seeded_in  = seeded_ff || accept;
      job_v_in   = accept ? 1'b1 : (take ? 1'b0 : job_v_ff);
      state_in   = state_ff;
      cal_cnt_in = cal_cnt_ff;
      ptr_in     = ptr_ff;
      x_sum_in   = x_sum_ff;
      y_sum_in   = y_sum_ff;
      z_sum_in   = z_sum_ff;
      bias_x_in  = bias_x_ff;
      bias_y_in  = bias_y_ff;
      bias_z_in  = bias_z_ff;
      mem_we     = 1'b0;
      mem_addr   = ptr_ff;
      r1_v_in    = 1'b0;

      div_req.valid = (state_ff != ST_IDLE);
      div_req.sel   = ilgb_pkg::BIAS_Z;
      div_req.sum   = z_sum_ff;

      if (take && !cal_done) begin
         x_sum_in   = x_sum_ff + 32'(filt[ilgb_pkg::AXIS_GX]);
         y_sum_in   = y_sum_ff + 32'(filt[ilgb_pkg::AXIS_GY]);
         z_sum_in   = z_sum_ff + 32'(filt[ilgb_pkg::AXIS_GZ]);
         mem_we     = 1'b1;
         mem_addr   = cal_cnt_ff[AW-1:0];
         cal_cnt_in = cal_cnt_ff + CW'(1);
         if (cal_cnt_ff == CW'(WINDOW - 1)) begin
            state_in = ST_ISSUE_X;
         end
      end

      if (take && cal_done) begin
         r1_v_in = 1'b1;
         if (still) begin
            // The oldest entry leaves the window sum; the new z value takes its place.
            z_sum_in = z_sum_ff - 32'(rd_ff) + 32'(filt[ilgb_pkg::AXIS_GZ]);
            mem_we   = 1'b1;
            ptr_in   = (ptr_ff == AW'(WINDOW - 1)) ? '0 : ptr_ff + AW'(1);
            state_in = ST_ISSUE_Z;
         end
      end

      case (state_ff)
         ST_ISSUE_X: begin
            div_req.sel = ilgb_pkg::BIAS_X;
            div_req.sum = x_sum_ff;
            state_in    = ST_ISSUE_Y;
         end
         ST_ISSUE_Y: begin
            div_req.sel = ilgb_pkg::BIAS_Y;
            div_req.sum = y_sum_ff;
            state_in    = ST_ISSUE_Z;
         end
         ST_ISSUE_Z: begin
            state_in = ST_IDLE;
         end
         default: ;
      endcase

      pend_in = pend_ff + 2'(div_req.valid) - 2'(div_rsp.valid);

      if (div_rsp.valid) begin
         case (div_rsp.sel)
            ilgb_pkg::BIAS_X: bias_x_in = div_rsp.mean;
            ilgb_pkg::BIAS_Y: bias_y_in = div_rsp.mean;
            default:          bias_z_in = div_rsp.mean;
         endcase
      end

      out_v_in = r2_v_ff ? 1'b1 : (rsp_tready ? 1'b0 : out_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff  <= 1'b0;
         job_v_ff   <= 1'b0;
         state_ff   <= ST_IDLE;
         pend_ff    <= 2'd0;
         cal_cnt_ff <= '0;
         ptr_ff     <= '0;
         x_sum_ff   <= '0;
         y_sum_ff   <= '0;
         z_sum_ff   <= '0;
         bias_x_ff  <= '0;
         bias_y_ff  <= '0;
         bias_z_ff  <= '0;
         r1_v_ff    <= 1'b0;
         r2_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         seeded_ff  <= seeded_in;
         job_v_ff   <= job_v_in;
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         cal_cnt_ff <= cal_cnt_in;
         ptr_ff     <= ptr_in;
         x_sum_ff   <= x_sum_in;
         y_sum_ff   <= y_sum_in;
         z_sum_ff   <= z_sum_in;
         bias_x_ff  <= bias_x_in;
         bias_y_ff  <= bias_y_in;
         bias_z_ff  <= bias_z_in;
         r1_v_ff    <= r1_v_in;
         r2_v_ff    <= r1_v_ff;
         out_v_ff   <= out_v_in;
      end
   end

   // The read port follows the replacement pointer so the oldest entry is ready.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[mem_addr] <= filt[ilgb_pkg::AXIS_GZ];
      end
      rd_ff <= win_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (r1_v_in) begin
         a1_ff[0]  <= filt[ilgb_pkg::AXIS_AX];
         a1_ff[1]  <= filt[ilgb_pkg::AXIS_AY];
         a1_ff[2]  <= filt[ilgb_pkg::AXIS_AZ];
         d1_ff[0]  <= ilgb_pkg::diff_type'(filt[ilgb_pkg::AXIS_GX])
                    - ilgb_pkg::diff_type'(bias_x_ff);
         d1_ff[1]  <= ilgb_pkg::diff_type'(filt[ilgb_pkg::AXIS_GY])
                    - ilgb_pkg::diff_type'(bias_y_ff);
         d1_ff[2]  <= dz;
         still1_ff <= still;
      end
      a2_ff     <= a1_ff;
      still2_ff <= still1_ff;
      if (r2_v_ff) begin
         out_data_ff  <= {(still2_ff ? '0 : rate[2]), rate[1], rate[0],
                          a2_ff[2], a2_ff[1], a2_ff[0]};
         out_still_ff <= still2_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_still_ff;

   `ASSERT_IMPLY(a_div_tracked, clock, reset, div_rsp.valid, pend_ff != 2'd0,
      "mean result without a pending request")
   `ASSERT_IMPLY(a_no_result_in_cal, clock, reset, r1_v_ff, cal_cnt_ff == CW'(WINDOW),
      "result word started during calibration")
   `ASSERT_IMPLY(a_out_free, clock, reset, r2_v_ff, !out_v_ff,
      "result word would overwrite a waiting word")
   `ASSERT_NEXT(a_still_issues_z, clock, reset, take && cal_done && still,
      state_ff == ST_ISSUE_Z, "still word did not start a z bias update")

endmodule

`default_nettype wire

@@ dv/imu_lowpass_gyro_bias_tracker_tb.sv @@
// Self-checking testbench for the IMU low-pass filter and gyro bias tracker.
`timescale 1ns / 100ps

module imu_lowpass_gyro_bias_tracker_tb;

   localparam int WINDOW       = 100;
   localparam int QUIET_CYCLES = 24;

   typedef logic [ilgb_pkg::RAW_W-1:0] raw_type;

   // One raw IMU word: element i sits at bits 16*i, indexed by the AXIS_* constants.
   typedef logic [ilgb_pkg::NUM_AXES-1:0][ilgb_pkg::RAW_W-1:0] imu_word_type;

   // Last declared member lands in the lowest bits, matching the rsp_tdata layout.
   typedef struct packed {
      logic               z_still;
      ilgb_pkg::rate_type rate_z;
      ilgb_pkg::rate_type rate_y;
      ilgb_pkg::rate_type rate_x;
      ilgb_pkg::filt_type accel_z;
      ilgb_pkg::filt_type accel_y;
      ilgb_pkg::filt_type accel_x;
   } imu_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [95:0]  req_tdata = '0;
   logic         req_tvalid = 1'b0;
   wire          req_tready;
   wire  [143:0] rsp_tdata;
   wire  [0:0]   rsp_tuser;
   wire          rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_we = 1'b0;
   logic [0:0]   csr_index = '0;
   logic [10:0]  csr_wdata = '0;

   imu_lowpass_gyro_bias_tracker #(.WINDOW(WINDOW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: filters, calibration sums, z window and biases, all Q15.8.
   int          still_thr = int'(ilgb_pkg::THR_RESET);
   int          new_weight = int'(ilgb_pkg::WGT_RESET);
   longint      filt_state [ilgb_pkg::NUM_AXES];
   longint      z_hist [WINDOW];
   longint      z_hist_sum = 0;
   longint      gx_cal_sum = 0;
   longint      gy_cal_sum = 0;
   longint      bias_x = 0;
   longint      bias_y = 0;
   longint      bias_z = 0;
   int          hist_ptr = 0;
   int          cal_count = 0;

   imu_result_type predicted_outputs [$];
   int          error_count = 0;

   // Sender burst control and receiver stall control.
   bit          sender_gaps_on = 1'b1;
   int          burst_left = 0;
   bit          rsp_stalls_on = 1'b1;
   int          rsp_hold_request = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          ready_left = 0;

   imu_result_type got_result;
   imu_result_type want_result;

   // Divide by a positive constant, rounding to nearest with ties away from zero.
   function automatic longint round_div(longint num, longint den);
      if (num >= 0)
         return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint gyro_rate(longint diff);
      return round_div(diff * longint'(ilgb_pkg::RATE_GAIN), longint'(1) << 24);
   endfunction

   task automatic track_gyro_bias(input imu_word_type w, output bit produced,
                                  output imu_result_type r);
      longint raw;
      longint wgt;
      longint dz;
      longint mag;
      bit     is_still;
      produced = 1'b0;
      r = '0;
      wgt = (new_weight > 256) ? 256 : new_weight;
      for (int i = 0; i < ilgb_pkg::NUM_AXES; i++) begin
         raw = longint'($signed(w[i])) * 256;
         if (cal_count == 0)
            filt_state[i] = raw;
         else
            filt_state[i] = round_div((256 - wgt) * filt_state[i] + wgt * raw, 256);
      end
      if (cal_count < WINDOW) begin
         gx_cal_sum += filt_state[ilgb_pkg::AXIS_GX];
         gy_cal_sum += filt_state[ilgb_pkg::AXIS_GY];
         z_hist[cal_count] = filt_state[ilgb_pkg::AXIS_GZ];
         z_hist_sum += filt_state[ilgb_pkg::AXIS_GZ];
         cal_count++;
         if (cal_count == WINDOW) begin
            bias_x = round_div(gx_cal_sum, WINDOW);
            bias_y = round_div(gy_cal_sum, WINDOW);
            bias_z = round_div(z_hist_sum, WINDOW);
         end
      end else begin
         dz = filt_state[ilgb_pkg::AXIS_GZ] - bias_z;
         mag = (dz < 0) ? -dz : dz;
         is_still = mag < longint'(still_thr) * 256;
         if (is_still) begin
            // The oldest window entry gives way and the z bias follows the new mean.
            z_hist_sum = z_hist_sum - z_hist[hist_ptr] + filt_state[ilgb_pkg::AXIS_GZ];
            z_hist[hist_ptr] = filt_state[ilgb_pkg::AXIS_GZ];
            bias_z = round_div(z_hist_sum, WINDOW);
            hist_ptr = (hist_ptr + 1 >= WINDOW) ? 0 : hist_ptr + 1;
         end
         produced = 1'b1;
         r.accel_x = ilgb_pkg::filt_type'(filt_state[ilgb_pkg::AXIS_AX]);
         r.accel_y = ilgb_pkg::filt_type'(filt_state[ilgb_pkg::AXIS_AY]);
         r.accel_z = ilgb_pkg::filt_type'(filt_state[ilgb_pkg::AXIS_AZ]);
         r.rate_x  = ilgb_pkg::rate_type'(gyro_rate(filt_state[ilgb_pkg::AXIS_GX] - bias_x));
         r.rate_y  = ilgb_pkg::rate_type'(gyro_rate(filt_state[ilgb_pkg::AXIS_GY] - bias_y));
         r.rate_z  = is_still ? '0 : ilgb_pkg::rate_type'(gyro_rate(dz));
         r.z_still = is_still;
      end
   endtask

   function automatic imu_word_type random_word();
      imu_word_type w;
      w = {$urandom(), $urandom(), $urandom()};
      for (int i = 0; i < ilgb_pkg::NUM_AXES; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: w[i] = 16'h7FFF;
               1: w[i] = 16'h8000;
               2: w[i] = 16'h0000;
               default: w[i] = 16'hFFFF;
            endcase
         end
      end
      return w;
   endfunction

   // Random word whose gyro z sits at the given raw offset from the current z bias.
   function automatic imu_word_type near_bias_word(int offset);
      imu_word_type w;
      int           zr;
      w = random_word();
      zr = int'(round_div(bias_z, 256)) + offset;
      if (zr > 32767)
         zr = 32767;
      if (zr < -32768)
         zr = -32768;
      w[ilgb_pkg::AXIS_GZ] = raw_type'(zr);
      return w;
   endfunction

   task automatic offer_word(input imu_word_type w);
      bit             produced;
      imu_result_type r;
      req_tdata <= w;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      track_gyro_bias(w, produced, r);
      if (produced)
         predicted_outputs.push_back(r);
      if (sender_gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 15);
            req_tvalid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(8, 25)) @(posedge clock);
            else
               repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // Drop valid, wait for every predicted word, then let the block settle.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (predicted_outputs.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [0:0] idx, input logic [10:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == ilgb_pkg::CSR_STILL_THRESHOLD)
         still_thr = int'(val);
      else
         new_weight = int'(val[ilgb_pkg::WGT_W-1:0]);
   endtask

   task automatic note_mismatch(input string what, input longint want, input longint got);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Receiver: random ready runs and stalls, plus long hold-offs on request.
   always @(posedge clock) begin
      if (rsp_hold_request > 0) begin
         hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (ready_left > 0) begin
            ready_left--;
         end else begin
            ready_left = $urandom_range(0, 10);
            stall_left = rsp_stalls_on ? $urandom_range(1, 7) : 0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result = {rsp_tuser, rsp_tdata};
         if (predicted_outputs.size() == 0) begin
            note_mismatch("unexpected result word", 0, 1);
         end else begin
            want_result = predicted_outputs.pop_front();
            if (got_result.accel_x != want_result.accel_x)
               note_mismatch("accel_x_filtered", $signed(want_result.accel_x),
                             $signed(got_result.accel_x));
            if (got_result.accel_y != want_result.accel_y)
               note_mismatch("accel_y_filtered", $signed(want_result.accel_y),
                             $signed(got_result.accel_y));
            if (got_result.accel_z != want_result.accel_z)
               note_mismatch("accel_z_filtered", $signed(want_result.accel_z),
                             $signed(got_result.accel_z));
            if (got_result.rate_x != want_result.rate_x)
               note_mismatch("rate_x", $signed(want_result.rate_x), $signed(got_result.rate_x));
            if (got_result.rate_y != want_result.rate_y)
               note_mismatch("rate_y", $signed(want_result.rate_y), $signed(got_result.rate_y));
            if (got_result.rate_z != want_result.rate_z)
               note_mismatch("rate_z", $signed(want_result.rate_z), $signed(got_result.rate_z));
            if (got_result.z_still != want_result.z_still)
               note_mismatch("z_still", want_result.z_still, got_result.z_still);
         end
      end
   end

   // The first word seeds the filters; the first WINDOW words fill the bias sums.
   task automatic test_calibration();
      imu_word_type w;
      write_register(ilgb_pkg::CSR_STILL_THRESHOLD, 11'd16);
      write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd182);
      for (int n = 0; n < WINDOW; n++) begin
         w = random_word();
         w[ilgb_pkg::AXIS_GX] = raw_type'(-300 + $urandom_range(0, 100) - 50);
         w[ilgb_pkg::AXIS_GY] = raw_type'(150 + $urandom_range(0, 100) - 50);
         w[ilgb_pkg::AXIS_GZ] = raw_type'(20 + $urandom_range(0, 10) - 5);
         offer_word(w);
      end
      wait_for_quiet();
   endtask

   task automatic test_directed_extremes();
      write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd256);
      offer_word({ilgb_pkg::NUM_AXES{16'h7FFF}});
      offer_word({ilgb_pkg::NUM_AXES{16'h8000}});
      offer_word({ilgb_pkg::NUM_AXES{16'h0000}});
      offer_word({ilgb_pkg::NUM_AXES{16'hFFFF}});
      offer_word({ilgb_pkg::NUM_AXES{16'h5555}});
      offer_word({ilgb_pkg::NUM_AXES{16'hAAAA}});
      // Walk gyro z across the threshold edge around the bias.
      offer_word(near_bias_word(0));
      offer_word(near_bias_word(15));
      offer_word(near_bias_word(16));
      offer_word(near_bias_word(-16));
      wait_for_quiet();
      // Zero weight freezes the filters.
      write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd0);
      offer_word(random_word());
      offer_word(random_word());
      wait_for_quiet();
      // A weight beyond full scale behaves like full scale.
      write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd511);
      offer_word(random_word());
      offer_word(near_bias_word(0));
      wait_for_quiet();
      // A zero threshold never reports still.
      write_register(ilgb_pkg::CSR_STILL_THRESHOLD, 11'd0);
      write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd256);
      offer_word(near_bias_word(0));
      offer_word(near_bias_word(0));
      wait_for_quiet();
      write_register(ilgb_pkg::CSR_STILL_THRESHOLD, 11'd1024);
      offer_word(near_bias_word(1023));
      offer_word(near_bias_word(-1024));
      offer_word(near_bias_word(-1100));
      wait_for_quiet();
      write_register(ilgb_pkg::CSR_STILL_THRESHOLD, ilgb_pkg::THR_RESET);
      write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'(ilgb_pkg::WGT_RESET));
   endtask

   // Mostly still gyro z around the bias, so the window keeps rolling.
   task automatic test_still_window();
      int thr_pick [4];
      int span;
      thr_pick[0] = 8;
      thr_pick[1] = 64;
      thr_pick[2] = 1024;
      thr_pick[3] = $urandom_range(1, 1024);
      for (int ph = 0; ph < 4; ph++) begin
         write_register(ilgb_pkg::CSR_STILL_THRESHOLD, 11'(thr_pick[ph]));
         case (ph)
            0: write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd182);
            1: write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd256);
            default: write_register(ilgb_pkg::CSR_FILTER_WEIGHT,
                                    11'($urandom_range(1, 256)));
         endcase
         span = (thr_pick[ph] < 4 ? 4 : thr_pick[ph]) + 4;
         for (int n = 0; n < 130; n++) begin
            if ($urandom_range(0, 99) < 85)
               offer_word(near_bias_word(int'($urandom_range(0, 2 * span)) - span));
            else
               offer_word(random_word());
         end
         wait_for_quiet();
      end
   endtask

   task automatic test_random_words();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_register(ilgb_pkg::CSR_STILL_THRESHOLD, 11'd0);
            1: write_register(ilgb_pkg::CSR_STILL_THRESHOLD, 11'd1024);
            default: write_register(ilgb_pkg::CSR_STILL_THRESHOLD,
                                    11'($urandom_range(0, 1024)));
         endcase
         case (ph)
            0: write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd256);
            1: write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'($urandom_range(257, 511)));
            2: write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'($urandom_range(0, 256)));
            default: write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd0);
         endcase
         for (int n = 0; n < 120; n++) begin
            if ($urandom_range(0, 3) == 0)
               offer_word(near_bias_word(int'($urandom_range(0, 40)) - 20));
            else
               offer_word(random_word());
         end
         wait_for_quiet();
      end
   endtask

   // Hold the receiver off while words keep coming, then run with no idling at all.
   task automatic test_backpressure();
      write_register(ilgb_pkg::CSR_STILL_THRESHOLD, 11'd32);
      write_register(ilgb_pkg::CSR_FILTER_WEIGHT, 11'd182);
      sender_gaps_on = 1'b0;
      rsp_hold_request = 400;
      for (int n = 0; n < 80; n++)
         offer_word(near_bias_word(int'($urandom_range(0, 80)) - 40));
      wait_for_quiet();
      rsp_stalls_on = 1'b0;
      for (int n = 0; n < 60; n++)
         offer_word(near_bias_word(int'($urandom_range(0, 80)) - 40));
      wait_for_quiet();
      rsp_stalls_on = 1'b1;
      sender_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_calibration();
      test_directed_extremes();
      test_still_window();
      test_random_words();
      test_backpressure();
      wait_for_quiet();
      if (error_count == 0 && predicted_outputs.size() == 0)
         $display("PASS imu_lowpass_gyro_bias_tracker");
      else
         $display("FAIL imu_lowpass_gyro_bias_tracker");
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL imu_lowpass_gyro_bias_tracker");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ilgb_pkg.sv
hdl/ilgb_filter_lane.sv
hdl/ilgb_rate_lane.sv
hdl/ilgb_mean_div.sv
hdl/imu_lowpass_gyro_bias_tracker.sv
dv/imu_lowpass_gyro_bias_tracker_tb.sv
